FILE: design/cbcr_pkg.sv
// Shared types and constants for the circle/box collision and reflection core.
package cbcr_pkg;

    // Quotient bits of the reflection divider, one per pipeline step.
    localparam int Q_W = 35;
    // Width of the doubled numerator 2*|v.d|*|d_i|.
    localparam int N_W = 97;
    // Remainder and divisor width.
    localparam int R_W = 64;

    typedef struct packed {
        logic signed [31:0] box_center_x;
        logic signed [31:0] box_center_y;
        logic        [30:0] box_width;
        logic        [30:0] box_height;
        logic signed [31:0] circle_center_x;
        logic signed [31:0] circle_center_y;
        logic        [30:0] radius;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } cbcr_in_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
    } cbcr_out_t;

    typedef struct packed {
        logic signed [32:0] c2x;
        logic signed [32:0] c2y;
        logic signed [33:0] lox;
        logic signed [33:0] hix;
        logic signed [33:0] loy;
        logic signed [33:0] hiy;
        logic        [30:0] radius;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } cbcr_a_t;

    typedef struct packed {
        logic        [31:0] adx;
        logic        [31:0] ady;
        logic               big;
        logic               dxneg;
        logic               dyneg;
        logic        [31:0] r2;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } cbcr_b_t;

    typedef struct packed {
        logic        [63:0] sqx;
        logic        [63:0] sqy;
        logic        [63:0] rr;
        logic        [63:0] ap;
        logic        [63:0] aq;
        logic        [31:0] adx;
        logic        [31:0] ady;
        logic               big;
        logic               dxneg;
        logic               dyneg;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } cbcr_c_t;

    typedef struct packed {
        logic        [63:0] dm;
        logic    [R_W-1:0]  den;
        logic        [31:0] adx;
        logic        [31:0] ady;
        logic               dneg;
        logic               dxneg;
        logic               dyneg;
        logic               hit;
        logic               refl;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } cbcr_d_t;

    typedef struct packed {
        logic        [63:0] pxl;
        logic        [63:0] pxh;
        logic        [63:0] pyl;
        logic        [63:0] pyh;
        logic    [R_W-1:0]  den;
        logic               dneg;
        logic               dxneg;
        logic               dyneg;
        logic               hit;
        logic               refl;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } cbcr_e_t;

    typedef struct packed {
        logic    [R_W-1:0]  rem_x;
        logic    [R_W-1:0]  rem_y;
        logic    [R_W-1:0]  den;
        logic    [Q_W-1:0]  nlo_x;
        logic    [Q_W-1:0]  nlo_y;
        logic    [Q_W-1:0]  q_x;
        logic    [Q_W-1:0]  q_y;
        logic               dneg;
        logic               dxneg;
        logic               dyneg;
        logic               hit;
        logic               refl;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } cbcr_div_t;

endpackage

FILE: design/circle_box_collide_reflect_core.sv
// Pipelined circle versus box collision test with velocity reflection.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------
//  s_      | in  | s_valid / s_ready  | s_data : box, circle, velocity
//  m_      | out | m_valid / m_ready  | m_data : hit, reflected velocity
//
// One request enters per cycle while s_ready is high; the accepting edge loads
// stage a, behind which come four more arithmetic stages, the divider load stage,
// 35 one-bit divider steps and the output register. The restoring divider, one
// quotient bit per stage, sets the depth.
// Reset (aresetn, synchronous, active low) clears all valid bits; payload is not reset.
// A stalled result is held in the output register and a one-entry skid register;
// the pipeline halts only when both are full, so nothing is lost or repeated.
module circle_box_collide_reflect_core import cbcr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  cbcr_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output cbcr_out_t m_data
);

    // One restoring division step on both axes.
    function automatic cbcr_div_t div_step(input cbcr_div_t d);
        cbcr_div_t  r;
        logic [R_W:0] tx;
        logic [R_W:0] ty;
        logic       gx;
        logic       gy;
        r  = d;
        tx = {d.rem_x, d.nlo_x[Q_W-1]};
        ty = {d.rem_y, d.nlo_y[Q_W-1]};
        gx = tx >= {1'b0, d.den};
        gy = ty >= {1'b0, d.den};
        r.rem_x = gx ? R_W'(tx - {1'b0, d.den}) : tx[R_W-1:0];
        r.rem_y = gy ? R_W'(ty - {1'b0, d.den}) : ty[R_W-1:0];
        r.nlo_x = {d.nlo_x[Q_W-2:0], 1'b0};
        r.nlo_y = {d.nlo_y[Q_W-2:0], 1'b0};
        r.q_x   = {d.q_x[Q_W-2:0], gx};
        r.q_y   = {d.q_y[Q_W-2:0], gy};
        return r;
    endfunction

    // Round the quotient, apply the correction to v and saturate to Q16.16.
    function automatic logic signed [31:0] apply_corr(
        input logic signed [31:0] v,
        input logic [Q_W-1:0]     q,
        input logic [R_W-1:0]     rem,
        input logic [R_W-1:0]     den,
        input logic               add
    );
        logic            rnd;
        logic [Q_W:0]    c;
        logic signed [Q_W+2:0] ve;
        logic signed [Q_W+2:0] ce;
        logic signed [Q_W+2:0] s;
        rnd = {rem, 1'b0} >= {1'b0, den};
        c   = {1'b0, q} + (Q_W + 1)'(rnd);
        ve  = (Q_W + 3)'(v);
        ce  = $signed({2'b00, c});
        s   = add ? ve + ce : ve - ce;
        if (s[Q_W+2:31] == '0 || s[Q_W+2:31] == '1) begin
            return s[31:0];
        end else if (s[Q_W+2]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    logic        en;

    logic [4:0]  stage_v_reg;
    logic [Q_W:0] div_v_reg;

    cbcr_a_t     a_reg, a_next;
    cbcr_b_t     b_reg, b_next;
    cbcr_c_t     c_reg, c_next;
    cbcr_d_t     d_reg, d_next;
    cbcr_e_t     e_reg, e_next;
    cbcr_div_t   div_reg  [0:Q_W];
    cbcr_div_t   div_next [0:Q_W];

    cbcr_out_t   res;
    cbcr_out_t   out_reg;
    cbcr_out_t   skid_reg;
    logic        out_v_reg;
    logic        skid_v_reg;

    // Advance the whole pipeline unless the skid register is occupied.
    assign en      = !skid_v_reg;
    assign s_ready = en;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    // Stage a: box edges and circle centre in doubled units (Q16.17), exact.
    always_comb begin
        a_next.c2x    = $signed({s_data.circle_center_x, 1'b0});
        a_next.c2y    = $signed({s_data.circle_center_y, 1'b0});
        a_next.lox    = $signed({s_data.box_center_x[31], s_data.box_center_x, 1'b0})
                      - $signed({3'b000, s_data.box_width});
        a_next.hix    = $signed({s_data.box_center_x[31], s_data.box_center_x, 1'b0})
                      + $signed({3'b000, s_data.box_width});
        a_next.loy    = $signed({s_data.box_center_y[31], s_data.box_center_y, 1'b0})
                      - $signed({3'b000, s_data.box_height});
        a_next.hiy    = $signed({s_data.box_center_y[31], s_data.box_center_y, 1'b0})
                      + $signed({3'b000, s_data.box_height});
        a_next.radius = s_data.radius;
        a_next.vel_x  = s_data.vel_x;
        a_next.vel_y  = s_data.vel_y;
    end

    // Stage b: clamp to the box and take d = centre - closest point as sign and magnitude.
    always_comb begin
        logic signed [34:0] cx, cy, dx, dy;
        logic        [34:0] mx, my;
        cx = 35'(a_reg.c2x);
        cy = 35'(a_reg.c2y);
        if (cx < 35'(a_reg.lox)) begin
            dx = cx - 35'(a_reg.lox);
        end else if (cx > 35'(a_reg.hix)) begin
            dx = cx - 35'(a_reg.hix);
        end else begin
            dx = '0;
        end
        if (cy < 35'(a_reg.loy)) begin
            dy = cy - 35'(a_reg.loy);
        end else if (cy > 35'(a_reg.hiy)) begin
            dy = cy - 35'(a_reg.hiy);
        end else begin
            dy = '0;
        end
        mx = dx[34] ? 35'(-dx) : 35'(dx);
        my = dy[34] ? 35'(-dy) : 35'(dy);
        b_next.adx   = mx[31:0];
        b_next.ady   = my[31:0];
        // A component of 2^32 or more lies beyond any radius: no hit.
        b_next.big   = (mx[34:32] != '0) || (my[34:32] != '0);
        b_next.dxneg = dx[34];
        b_next.dyneg = dy[34];
        b_next.r2    = {a_reg.radius, 1'b0};
        b_next.vel_x = a_reg.vel_x;
        b_next.vel_y = a_reg.vel_y;
    end

    // Stage c: squares and the magnitudes of the dot product terms.
    always_comb begin
        logic [31:0] avx, avy;
        avx = b_reg.vel_x[31] ? 32'(-b_reg.vel_x) : 32'(b_reg.vel_x);
        avy = b_reg.vel_y[31] ? 32'(-b_reg.vel_y) : 32'(b_reg.vel_y);
        c_next.sqx   = {32'b0, b_reg.adx} * {32'b0, b_reg.adx};
        c_next.sqy   = {32'b0, b_reg.ady} * {32'b0, b_reg.ady};
        c_next.rr    = {32'b0, b_reg.r2} * {32'b0, b_reg.r2};
        c_next.ap    = {32'b0, avx} * {32'b0, b_reg.adx};
        c_next.aq    = {32'b0, avy} * {32'b0, b_reg.ady};
        c_next.adx   = b_reg.adx;
        c_next.ady   = b_reg.ady;
        c_next.big   = b_reg.big;
        c_next.dxneg = b_reg.dxneg;
        c_next.dyneg = b_reg.dyneg;
        c_next.vel_x = b_reg.vel_x;
        c_next.vel_y = b_reg.vel_y;
    end

    // Stage d: hit test, then |v.d| and its sign.
    always_comb begin
        logic [64:0] dd;
        logic        ps, qs;
        dd = {1'b0, c_reg.sqx} + {1'b0, c_reg.sqy};
        ps = (c_reg.vel_x[31] ^ c_reg.dxneg) && (c_reg.ap != '0);
        qs = (c_reg.vel_y[31] ^ c_reg.dyneg) && (c_reg.aq != '0);
        d_next.hit  = !c_reg.big && (dd <= {1'b0, c_reg.rr});
        // Centre inside the box: d is zero and the velocity passes through.
        d_next.refl = d_next.hit && ((c_reg.adx | c_reg.ady) != '0);
        d_next.den  = dd[R_W-1:0];
        if (ps == qs) begin
            d_next.dm   = c_reg.ap + c_reg.aq;
            d_next.dneg = ps;
        end else if (c_reg.ap >= c_reg.aq) begin
            d_next.dm   = c_reg.ap - c_reg.aq;
            d_next.dneg = ps;
        end else begin
            d_next.dm   = c_reg.aq - c_reg.ap;
            d_next.dneg = qs;
        end
        d_next.adx   = c_reg.adx;
        d_next.ady   = c_reg.ady;
        d_next.dxneg = c_reg.dxneg;
        d_next.dyneg = c_reg.dyneg;
        d_next.vel_x = c_reg.vel_x;
        d_next.vel_y = c_reg.vel_y;
    end

    // Stage e: |v.d| * |d_i| as two 32x32 partial products per axis.
    always_comb begin
        e_next.pxl   = {32'b0, d_reg.dm[31:0]} * {32'b0, d_reg.adx};
        e_next.pxh   = {32'b0, d_reg.dm[63:32]} * {32'b0, d_reg.adx};
        e_next.pyl   = {32'b0, d_reg.dm[31:0]} * {32'b0, d_reg.ady};
        e_next.pyh   = {32'b0, d_reg.dm[63:32]} * {32'b0, d_reg.ady};
        e_next.den   = d_reg.den;
        e_next.dneg  = d_reg.dneg;
        e_next.dxneg = d_reg.dxneg;
        e_next.dyneg = d_reg.dyneg;
        e_next.hit   = d_reg.hit;
        e_next.refl  = d_reg.refl;
        e_next.vel_x = d_reg.vel_x;
        e_next.vel_y = d_reg.vel_y;
    end

    // Divider load, then one quotient bit per stage. The quotient stays below
    // 2^35, so the top bits of the numerator already sit below the divisor.
    always_comb begin
        logic [95:0]    sx, sy;
        logic [N_W-1:0] nx, ny;
        sx = {e_reg.pxh, 32'b0} + {32'b0, e_reg.pxl};
        sy = {e_reg.pyh, 32'b0} + {32'b0, e_reg.pyl};
        nx = {sx, 1'b0};
        ny = {sy, 1'b0};
        div_next[0].rem_x = R_W'(nx[N_W-1:Q_W]);
        div_next[0].rem_y = R_W'(ny[N_W-1:Q_W]);
        div_next[0].nlo_x = nx[Q_W-1:0];
        div_next[0].nlo_y = ny[Q_W-1:0];
        div_next[0].q_x   = '0;
        div_next[0].q_y   = '0;
        div_next[0].den   = e_reg.den;
        div_next[0].dneg  = e_reg.dneg;
        div_next[0].dxneg = e_reg.dxneg;
        div_next[0].dyneg = e_reg.dyneg;
        div_next[0].hit   = e_reg.hit;
        div_next[0].refl  = e_reg.refl;
        div_next[0].vel_x = e_reg.vel_x;
        div_next[0].vel_y = e_reg.vel_y;
        for (int k = 1; k <= Q_W; k++) begin
            div_next[k] = div_step(div_reg[k-1]);
        end
    end

    // Result: round half away from zero, subtract along d, saturate.
    always_comb begin
        cbcr_div_t f;
        f = div_reg[Q_W];
        res.hit = f.hit;
        if (f.refl) begin
            res.out_vel_x = apply_corr(f.vel_x, f.q_x, f.rem_x, f.den, f.dneg != f.dxneg);
            res.out_vel_y = apply_corr(f.vel_y, f.q_y, f.rem_y, f.den, f.dneg != f.dyneg);
        end else begin
            res.out_vel_x = f.vel_x;
            res.out_vel_y = f.vel_y;
        end
    end

    // Pipeline payload: hold everything while the skid register is full.
    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
            for (int k = 0; k <= Q_W; k++) begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_v_reg <= '0;
            div_v_reg   <= '0;
        end else if (en) begin
            stage_v_reg <= {stage_v_reg[3:0], s_valid};
            div_v_reg   <= {div_v_reg[Q_W-1:0], stage_v_reg[4]};
        end
    end

    // Output register with one skid entry: drain the skid first, else take the
    // pipeline's last request; park it in the skid when the output is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || m_ready) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg  <= div_v_reg[Q_W];
            end
        end else if (div_v_reg[Q_W] && en) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || m_ready) begin
            out_reg <= skid_v_reg ? skid_reg : res;
        end else if (en) begin
            skid_reg <= res;
        end
    end

`ifndef NO_ASSERTIONS
    // The skid entry is only ever used behind a full output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry valid without a valid output");

    // Input backpressure appears only after a stalled output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(out_v_reg && !m_ready))
        else $error("s_ready dropped without an output stall");

    // A parked request stays parked, unchanged, while the output is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg && !m_ready |=> skid_v_reg && $stable(skid_reg))
        else $error("skid entry lost during stall");

    // Restoring division keeps the remainder below the divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_v_reg[Q_W] && div_reg[Q_W].refl |->
            (div_reg[Q_W].rem_x < div_reg[Q_W].den) &&
            (div_reg[Q_W].rem_y < div_reg[Q_W].den))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the circle/box collision and reflection core.
`timescale 1ns / 100ps

module testbench;
    import cbcr_pkg::*;

    localparam longint ONE        = 64'sd65536;
    localparam int     N_RANDOM   = 1380;
    localparam int     CYCLE_CAP  = 700000;
    localparam int     DRAIN_WAIT = 100;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    cbcr_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    cbcr_out_t m_data;

    cbcr_in_t  pending_reqs[$];
    cbcr_out_t bounce_q[$];

    int  cycle_cnt    = 0;
    int  error_cnt    = 0;
    int  checked_cnt  = 0;
    int  hit_cnt      = 0;
    int  sent_cnt     = 0;
    int  send_gap     = 0;
    int  stall_cnt    = 0;
    logic in_fire     = 1'b0;
    logic bench_live  = 1'b0;

    circle_box_collide_reflect_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 20 ns clock, free running.
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Watchdog: a correct run finishes far below this cap.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("timeout at %0t, %0d results still outstanding", $time, bounce_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Exact predictor. All positions are taken in doubled units so that the
    // half sizes of the box stay integral; squares and correction terms are carried at 128 bits.
    function automatic cbcr_out_t predict_bounce(cbcr_in_t it);
        longint bx2, by2, cx2, cy2, w, h, px, py, dx, dy, vx, vy, p, q, ox, oy;
        logic [127:0] adx, ady, dd, r2, rr, dm, ap, aq, nx, ny, cxm, cym, rem;
        logic dneg;
        cbcr_out_t res;
        bx2 = 2 * longint'(it.box_center_x);
        by2 = 2 * longint'(it.box_center_y);
        cx2 = 2 * longint'(it.circle_center_x);
        cy2 = 2 * longint'(it.circle_center_y);
        w   = longint'(it.box_width);
        h   = longint'(it.box_height);
        vx  = longint'(it.vel_x);
        vy  = longint'(it.vel_y);
        // Clamp the circle centre onto the box to get the closest point.
        px = (cx2 < bx2 - w) ? bx2 - w : (cx2 > bx2 + w) ? bx2 + w : cx2;
        py = (cy2 < by2 - h) ? by2 - h : (cy2 > by2 + h) ? by2 + h : cy2;
        dx = cx2 - px;
        dy = cy2 - py;
        adx = 128'(dx < 0 ? -dx : dx);
        ady = 128'(dy < 0 ? -dy : dy);
        dd  = adx * adx + ady * ady;
        r2  = 128'(it.radius) * 2;
        rr  = r2 * r2;
        res.hit = (dd <= rr);
        ox = vx;
        oy = vy;
        if (res.hit && (dx != 0 || dy != 0)) begin
            // Sign and magnitude of v.d, then the rounded correction per axis.
            p  = vx * dx;
            q  = vy * dy;
            ap = 128'(p < 0 ? -p : p);
            aq = 128'(q < 0 ? -q : q);
            if ((p < 0) == (q < 0)) begin
                dm = ap + aq;
                dneg = (p < 0);
            end else if (ap >= aq) begin
                dm = ap - aq;
                dneg = (p < 0);
            end else begin
                dm = aq - ap;
                dneg = (q < 0);
            end
            nx  = 2 * dm * adx;
            ny  = 2 * dm * ady;
            cxm = nx / dd;
            rem = nx % dd;
            if (rem >= dd - rem) cxm = cxm + 1;
            cym = ny / dd;
            rem = ny % dd;
            if (rem >= dd - rem) cym = cym + 1;
            ox = (dneg != (dx < 0)) ? vx + longint'(cxm) : vx - longint'(cxm);
            oy = (dneg != (dy < 0)) ? vy + longint'(cym) : vy - longint'(cym);
        end
        res.out_vel_x = (ox > 64'sd2147483647) ? 32'sh7fffffff :
                        (ox < -64'sd2147483648) ? 32'sh80000000 : 32'(ox);
        res.out_vel_y = (oy > 64'sd2147483647) ? 32'sh7fffffff :
                        (oy < -64'sd2147483648) ? 32'sh80000000 : 32'(oy);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one, and stretches with no gap at all.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if ((cycle_cnt / 3000) % 4 == 1) return 0;
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic queue_req(longint bx, longint by, longint w, longint h,
                             longint cx, longint cy, longint r, longint vx, longint vy);
        cbcr_in_t it;
        it.box_center_x    = 32'(bx);
        it.box_center_y    = 32'(by);
        it.box_width       = 31'(w);
        it.box_height      = 31'(h);
        it.circle_center_x = 32'(cx);
        it.circle_center_y = 32'(cy);
        it.radius          = 31'(r);
        it.vel_x           = 32'(vx);
        it.vel_y           = 32'(vy);
        pending_reqs.push_back(it);
    endtask

    // Request side: advance to the next request only after a handshake.
    always @(negedge aclk) begin
        if (bench_live) begin
            if (s_valid && !in_fire) begin
                // hold the current request
            end else if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                s_valid  <= 1'b1;
                s_data   <= pending_reqs.pop_front();
                send_gap <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side backpressure.
    always @(negedge aclk) begin
        if (bench_live) begin
            if (stall_cnt > 0) begin
                m_ready   <= 1'b0;
                stall_cnt <= stall_cnt - 1;
            end else begin
                m_ready   <= 1'b1;
                stall_cnt <= pick_gap();
            end
        end
    end

    // Predict every accepted request.
    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            bounce_q.push_back(predict_bounce(s_data));
            sent_cnt <= sent_cnt + 1;
        end
    end

    // Compare each delivered result with the oldest prediction.
    always @(posedge aclk) begin
        cbcr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bounce_q.size() == 0) begin
                $display("%0t: unexpected result hit=%0b vx=%0d vy=%0d", $time,
                         m_data.hit, m_data.out_vel_x, m_data.out_vel_y);
                error_cnt = error_cnt + 1;
            end else begin
                want = bounce_q.pop_front();
                checked_cnt <= checked_cnt + 1;
                if (want.hit) hit_cnt <= hit_cnt + 1;
                if (m_data.hit !== want.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_data.hit);
                    error_cnt = error_cnt + 1;
                end
                if (m_data.out_vel_x !== want.out_vel_x) begin
                    $display("%0t: out_vel_x expected %0d actual %0d", $time,
                             want.out_vel_x, m_data.out_vel_x);
                    error_cnt = error_cnt + 1;
                end
                if (m_data.out_vel_y !== want.out_vel_y) begin
                    $display("%0t: out_vel_y expected %0d actual %0d", $time,
                             want.out_vel_y, m_data.out_vel_y);
                    error_cnt = error_cnt + 1;
                end
            end
        end
    end

    initial begin
        longint bx, by, w, h, cx, cy, r, reach;
        int     n;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;

        // Directed: centre inside, edge touch and miss, corners, point
        // circles, degenerate boxes, extreme fields and saturation.
        queue_req(0, 0, 4*ONE, 4*ONE, ONE/2, -ONE/3, ONE, 3*ONE, -ONE);
        queue_req(0, 0, 2*ONE, 2*ONE, 2*ONE, 0, ONE, -ONE, 0);
        queue_req(0, 0, 2*ONE, 2*ONE, 2*ONE + 1, 0, ONE, -ONE, 0);
        queue_req(0, 0, 2*ONE, 2*ONE, 3*ONE/2, 3*ONE/2, ONE, -ONE, -2*ONE);
        queue_req(0, 0, 2*ONE, 2*ONE, 2*ONE, 2*ONE, ONE, -ONE, -ONE);
        queue_req(0, 0, 2*ONE, 2*ONE, ONE, ONE/2, 0, 5*ONE, 7);
        queue_req(0, 0, 2*ONE, 2*ONE, ONE + 1, 0, 0, 5*ONE, 7);
        queue_req(ONE, ONE, 0, 0, 4*ONE, 5*ONE, 5*ONE, -3*ONE, 2*ONE);
        queue_req(ONE, ONE, 0, 0, ONE, ONE, 0, 9, -9);
        queue_req(0, 0, 0, 6*ONE, 3, 2*ONE, 3, -ONE, ONE);
        queue_req(0, 0, 2*ONE, 2*ONE, 3*ONE, 0, 2*ONE, -64'sd2147483648, 12345);
        queue_req(0, 0, 2*ONE, 2*ONE, 0, 3*ONE, 2*ONE, 64'sd2147483647, 64'sd2147483647);
        queue_req(0, 0, 2*ONE, 2*ONE, 3*ONE, 0, 2*ONE, 0, 0);
        queue_req(0, 0, 2*ONE, 2*ONE, 3*ONE, 0, 2*ONE, 0, 4*ONE);
        queue_req(64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                  64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                  64'sd2147483647, 64'sd2147483647);
        queue_req(-64'sd2147483648, -64'sd2147483648, 0, 0, -64'sd2147483648,
                  -64'sd2147483648, 0, -64'sd2147483648, -64'sd2147483648);
        queue_req(-64'sd2147483648, -64'sd2147483648, 0, 0, 64'sd2147483647,
                  64'sd2147483647, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
        queue_req(-64'sd2147483648, 0, 64'sd2147483647, 0, 64'sd2147483647,
                  -64'sd2147483648, 64'sd2147483647, 64'sd2147483647, -64'sd2147483648);
        queue_req(0, 0, 2, 2, 3, 3, 1, 1, -1);
        queue_req(0, 0, 1, 1, 1, 1, 1, 3, 5);

        // Random: most requests place the circle close to the box so that
        // hits, edge grazes and near misses dominate; the rest is raw noise.
        for (n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(99) < 25) begin
                queue_req(longint'($signed($urandom())), longint'($signed($urandom())),
                          longint'($urandom() >> 1), longint'($urandom() >> 1),
                          longint'($signed($urandom())), longint'($signed($urandom())),
                          longint'($urandom() >> 1), longint'($signed($urandom())),
                          longint'($signed($urandom())));
            end else begin
                bx = longint'($signed($urandom())) >>> 3;
                by = longint'($signed($urandom())) >>> 3;
                w  = $urandom_range(32'h0100_0000);
                h  = $urandom_range(32'h0100_0000);
                r  = ($urandom_range(3) == 0) ? 0 : $urandom_range(32'h0040_0000);
                reach = r + 2;
                cx = bx + (w/2 + reach) - longint'($urandom_range(32'(w + 2*reach)));
                cy = by + (h/2 + reach) - longint'($urandom_range(32'(h + 2*reach)));
                queue_req(bx, by, w, h, cx, cy, r,
                          longint'($signed($urandom())) >>> $urandom_range(20),
                          longint'($signed($urandom())) >>> $urandom_range(20));
            end
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn    = 1'b1;
        bench_live = 1'b1;

        wait (pending_reqs.size() == 0 && !s_valid && bounce_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("checked %0d results from %0d requests, %0d of them hits",
                 checked_cnt, sent_cnt, hit_cnt);
        if (error_cnt == 0 && bounce_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: circle_box_collide_reflect_core.f
design/cbcr_pkg.sv
design/circle_box_collide_reflect_core.sv
bench/testbench.sv
